// ===== sv/assert_macros.svh =====
// Assertion macros shared by the validator RTL.
// Each macro assumes a clock named clk and a synchronous reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/jusv_pkg.sv =====
// Types and constants for the JSON-safe UTF-8 string validator.
// No dependencies; used by every module of the block.
`default_nettype none

package jusv_pkg;

  localparam int VERDICT_OFFSET_BITS = 16;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_string;
  } item_t;

  typedef struct packed {
    logic                           is_valid;
    logic [VERDICT_OFFSET_BITS-1:0] bad_offset;
  } verdict_t;

  // Allowed range of the next continuation byte.
  localparam logic [1:0] RC_FULL = 2'd0;  // 80..BF
  localparam logic [1:0] RC_E0   = 2'd1;  // A0..BF, after lead E0
  localparam logic [1:0] RC_ED   = 2'd2;  // 80..9F, after lead ED

  localparam logic [7:0] CONT_LO      = 8'h80;
  localparam logic [7:0] CONT_HI      = 8'hBF;
  localparam logic [7:0] CONT_LO_E0   = 8'hA0;
  localparam logic [7:0] CONT_HI_ED   = 8'h9F;

endpackage

`default_nettype wire

// ===== sv/json_utf8_string_validator.sv =====
// Top level of the JSON-safe UTF-8 string validator.
// Depends on jusv_pkg, jusv_in_stage and jusv_core.
`default_nettype none

// The validator takes one byte per cycle unless stalled; one verdict comes
// out for each end-of-string transaction. Accepted are printable ASCII
// 0x20..0x7E other than double quote and backslash, and well-formed two- and
// three-byte UTF-8 in the Basic Multilingual Plane, with no overlong forms
// and no surrogates. The verdict carries is_valid and the offset of the lead
// byte of the first bad sequence (zero when the string passes); only the
// first error is kept and offsets saturate. The block sustains one
// transaction per cycle apart from the stall below: the per-byte check is a
// single level of compare logic between the input register and the
// string-state registers. A verdict is loaded into the result register when
// its end transaction leaves the input register. While a verdict waits in the
// result register, data bytes keep flowing; a further end transaction, and
// every transaction behind it, waits in the input register until the pending
// verdict is taken, and moves on in the same cycle that the verdict is taken.
module json_utf8_string_validator #(
  parameter int OFFSET_BITS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          item_valid,
  output logic               item_ready,
  input  jusv_pkg::item_t    item,
  output logic               verdict_valid,
  input  wire logic          verdict_ready,
  output jusv_pkg::verdict_t verdict
);
  import jusv_pkg::*;

  // Registered byte transaction between the input stage and the checker.
  logic  held_valid;
  logic  held_ready;
  item_t held;

  jusv_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .held_valid (held_valid),
    .held_ready (held_ready),
    .held       (held)
  );

  // The checker holds the per-string state and the verdict register.
  jusv_core #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .held_valid    (held_valid),
    .held_ready    (held_ready),
    .held          (held),
    .verdict_valid (verdict_valid),
    .verdict_ready (verdict_ready),
    .verdict       (verdict)
  );

endmodule

`default_nettype wire

// ===== sv/jusv_in_stage.sv =====
// Input register of the validator: captures one transaction per cycle while its content can move on.
// Depends on jusv_pkg for the item type.
`default_nettype none

module jusv_in_stage (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           item_valid,
  output logic                item_ready,
  input  jusv_pkg::item_t     item,
  output logic                held_valid,
  input  wire logic           held_ready,
  output jusv_pkg::item_t     held
);
  import jusv_pkg::*;

  // The register refills in the same cycle that its content moves on.
  assign item_ready = !held_valid || held_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (item_ready) begin
      held_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      held <= item;
    end
  end

endmodule

`default_nettype wire

// ===== sv/jusv_core.sv =====
// String state, per-byte UTF-8 check and result register of the validator.
// Depends on jusv_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module jusv_core #(
  parameter int OFFSET_BITS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          held_valid,
  output logic               held_ready,
  input  jusv_pkg::item_t    held,
  output logic               verdict_valid,
  input  wire logic          verdict_ready,
  output jusv_pkg::verdict_t verdict
);
  import jusv_pkg::*;

  logic [1:0]             pend, pend_next;
  logic [1:0]             range_class, range_class_next;
  logic                   failed, failed_next;
  logic [OFFSET_BITS-1:0] pos, pos_next;
  logic [OFFSET_BITS-1:0] seq_start, seq_start_next;
  logic [OFFSET_BITS-1:0] err_off, err_off_next;

  logic                   out_free;
  logic                   take;
  logic [7:0]             b;
  logic [7:0]             lo, hi;
  logic [OFFSET_BITS-1:0] raw_off;
  logic [VERDICT_OFFSET_BITS-1:0] clamp_off;
  verdict_t               result;

  assign out_free   = !verdict_valid || verdict_ready;
  assign held_ready = out_free || !held.end_of_string;
  assign take       = held_valid && held_ready;
  assign b          = held.data_byte;

  assign lo = (range_class == RC_E0) ? CONT_LO_E0 : CONT_LO;
  assign hi = (range_class == RC_ED) ? CONT_HI_ED : CONT_HI;

  always_comb begin
    pend_next        = pend;
    range_class_next = range_class;
    failed_next      = failed;
    seq_start_next   = seq_start;
    err_off_next     = err_off;
    pos_next         = (pos == '1) ? pos : pos + 1'b1;
    if (held.end_of_string) begin
      pend_next        = '0;
      range_class_next = RC_FULL;
      failed_next      = 1'b0;
      pos_next         = '0;
      seq_start_next   = '0;
      err_off_next     = '0;
    end else if (!failed) begin
      if (pend == 2'd0) begin
        case (b) inside
          [8'h20:8'h21], [8'h23:8'h5B], [8'h5D:8'h7E]: begin
          end
          [8'hC2:8'hDF]: begin
            seq_start_next   = pos;
            pend_next        = 2'd1;
            range_class_next = RC_FULL;
          end
          8'hE0: begin
            seq_start_next   = pos;
            pend_next        = 2'd2;
            range_class_next = RC_E0;
          end
          [8'hE1:8'hEC], 8'hEE, 8'hEF: begin
            seq_start_next   = pos;
            pend_next        = 2'd2;
            range_class_next = RC_FULL;
          end
          8'hED: begin
            seq_start_next   = pos;
            pend_next        = 2'd2;
            range_class_next = RC_ED;
          end
          default: begin
            seq_start_next   = pos;
            failed_next      = 1'b1;
            err_off_next     = pos;
            pend_next        = '0;
            range_class_next = RC_FULL;
          end
        endcase
      end else if (b >= lo && b <= hi) begin
        pend_next        = pend - 1'b1;
        range_class_next = RC_FULL;
      end else begin
        // A bad continuation is charged to the lead byte of its sequence.
        failed_next      = 1'b1;
        err_off_next     = seq_start;
        pend_next        = '0;
        range_class_next = RC_FULL;
      end
    end
  end

  assign raw_off = failed ? err_off : ((pend != 2'd0) ? seq_start : '0);

  generate
    if (OFFSET_BITS > VERDICT_OFFSET_BITS) begin : g_clamp
      assign clamp_off = (|raw_off[OFFSET_BITS-1:VERDICT_OFFSET_BITS]) ? '1
                         : raw_off[VERDICT_OFFSET_BITS-1:0];
    end else begin : g_extend
      assign clamp_off = VERDICT_OFFSET_BITS'(raw_off);
    end
  endgenerate

  assign result.is_valid   = !failed && (pend == 2'd0);
  assign result.bad_offset = clamp_off;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend          <= '0;
      range_class   <= RC_FULL;
      failed        <= 1'b0;
      pos           <= '0;
      seq_start     <= '0;
      err_off       <= '0;
      verdict_valid <= 1'b0;
    end else begin
      if (take) begin
        pend        <= pend_next;
        range_class <= range_class_next;
        failed      <= failed_next;
        pos         <= pos_next;
        seq_start   <= seq_start_next;
        err_off     <= err_off_next;
      end
      if (take && held.end_of_string) begin
        verdict_valid <= 1'b1;
      end else if (verdict_ready) begin
        verdict_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && held.end_of_string) begin
      verdict <= result;
    end
  end

  `ASSERT_IMPLIES(a_fail_clears_pend, failed, pend == 2'd0, "pending bytes after an error")
  `ASSERT_IMPLIES(a_pend_range, 1'b1, pend != 2'd3, "more than two continuations pending")
  `ASSERT_IMPLIES(a_valid_zero_off, verdict_valid && verdict.is_valid,
    verdict.bad_offset == '0, "passing verdict with nonzero offset")
  `ASSERT_NEXT(a_end_clears, take && held.end_of_string, pos == '0 && !failed,
    "string state not cleared after end")

endmodule

`default_nettype wire

// ===== sim/utf8_verdict_checker.sv =====
// Checker for the JSON-safe UTF-8 string validator: watches both channels,
// predicts each verdict from the accepted bytes and compares. Uses jusv_pkg.
`timescale 1ns / 1ps

module utf8_verdict_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  logic               item_ready,
  input  jusv_pkg::item_t    item,
  input  logic               verdict_valid,
  input  logic               verdict_ready,
  input  jusv_pkg::verdict_t verdict,
  output int                 mismatches,
  output int                 outstanding
);
  import jusv_pkg::*;

  localparam int POS_BITS = VERDICT_OFFSET_BITS;
  localparam logic [POS_BITS-1:0] POS_MAX = '1;
  localparam int REPORT_LIMIT = 10;

  localparam logic [7:0] PRINT_LO  = 8'h20;
  localparam logic [7:0] PRINT_HI  = 8'h7E;
  localparam logic [7:0] QUOTE     = 8'h22;
  localparam logic [7:0] BACKSLASH = 8'h5C;
  localparam logic [7:0] LEAD2_LO  = 8'hC2;
  localparam logic [7:0] LEAD2_HI  = 8'hDF;
  localparam logic [7:0] LEAD_E0   = 8'hE0;
  localparam logic [7:0] LEAD_E1   = 8'hE1;
  localparam logic [7:0] LEAD_EC   = 8'hEC;
  localparam logic [7:0] LEAD_ED   = 8'hED;
  localparam logic [7:0] LEAD_EE   = 8'hEE;
  localparam logic [7:0] LEAD_EF   = 8'hEF;

  // Shadow of the string state inside the block.
  logic [1:0]          conts_left;
  logic [1:0]          cont_range;
  logic                seen_error;
  logic [POS_BITS-1:0] pos;
  logic [POS_BITS-1:0] lead_pos;
  logic [POS_BITS-1:0] error_pos;

  verdict_t expected_verdicts[$];
  int       mismatch_count = 0;

  task automatic clear_string();
    conts_left = 2'd0;
    cont_range = RC_FULL;
    seen_error = 1'b0;
    pos        = '0;
    lead_pos   = '0;
    error_pos  = '0;
  endtask

  task automatic flag_error(input logic [POS_BITS-1:0] at);
    seen_error = 1'b1;
    error_pos  = at;
    conts_left = 2'd0;
    cont_range = RC_FULL;
  endtask

  task automatic take_lead(input logic [7:0] b);
    if (b >= PRINT_LO && b <= PRINT_HI && b != QUOTE && b != BACKSLASH) return;
    lead_pos = pos;
    if (b >= LEAD2_LO && b <= LEAD2_HI) begin
      conts_left = 2'd1;
      cont_range = RC_FULL;
    end else if (b == LEAD_E0) begin
      conts_left = 2'd2;
      cont_range = RC_E0;
    end else if ((b >= LEAD_E1 && b <= LEAD_EC) || b == LEAD_EE || b == LEAD_EF) begin
      conts_left = 2'd2;
      cont_range = RC_FULL;
    end else if (b == LEAD_ED) begin
      conts_left = 2'd2;
      cont_range = RC_ED;
    end else begin
      flag_error(pos);
    end
  endtask

  task automatic take_continuation(input logic [7:0] b);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = (cont_range == RC_E0) ? CONT_LO_E0 : CONT_LO;
    hi = (cont_range == RC_ED) ? CONT_HI_ED : CONT_HI;
    if (b >= lo && b <= hi) begin
      conts_left = conts_left - 2'd1;
      cont_range = RC_FULL;
    end else begin
      // A bad continuation is charged to the lead byte of its sequence.
      flag_error(lead_pos);
    end
  endtask

  task automatic absorb_byte(input logic [7:0] b);
    if (!seen_error) begin
      if (conts_left == 2'd0) take_lead(b);
      else take_continuation(b);
    end
    if (pos != POS_MAX) pos = pos + 1'b1;
  endtask

  task automatic close_string(output verdict_t v);
    v.is_valid = !seen_error && conts_left == 2'd0;
    if (seen_error) v.bad_offset = error_pos;
    else if (conts_left != 2'd0) v.bad_offset = lead_pos;
    else v.bad_offset = '0;
    clear_string();
  endtask

  task automatic note_mismatch(input string what, input verdict_t want, input verdict_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("%t: verdict %s: expected is_valid=%0b bad_offset=%0d, got is_valid=%0b bad_offset=%0d",
               $realtime, what, want.is_valid, want.bad_offset, got.is_valid, got.bad_offset);
  endtask

  always @(posedge clk) begin
    verdict_t want;
    if (rst) begin
      clear_string();
      expected_verdicts.delete();
    end else begin
      if (item_valid && item_ready) begin
        if (item.end_of_string) begin
          close_string(want);
          expected_verdicts.push_back(want);
        end else begin
          absorb_byte(item.data_byte);
        end
      end
      if (verdict_valid && verdict_ready) begin
        if (expected_verdicts.size() == 0) begin
          note_mismatch("with none pending", '0, verdict);
        end else begin
          want = expected_verdicts.pop_front();
          if (verdict.is_valid !== want.is_valid || verdict.bad_offset !== want.bad_offset)
            note_mismatch("mismatch", want, verdict);
        end
      end
    end
    mismatches  <= mismatch_count;
    outstanding <= expected_verdicts.size();
  end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top for the JSON-safe UTF-8 string validator: clock, reset,
// byte-stream stimulus and the final verdict. Uses jusv_pkg and utf8_verdict_checker.
`timescale 1ns / 1ps

module tb_top;
  import jusv_pkg::*;

  localparam int HALF_PERIOD_NS = 2;
  localparam int RESET_CYCLES   = 5;
  localparam int RANDOM_ITEMS   = 600;
  localparam int TAIL_CYCLES    = 8;
  // The slowest correct run, with the longest idle gap before every
  // transaction and the longest verdict stall, stays under 100 us.
  localparam int TIMEOUT_NS     = 2_000_000;

  localparam logic [7:0] PRINT_LO  = 8'h20;
  localparam logic [7:0] PRINT_HI  = 8'h7E;
  localparam logic [7:0] QUOTE     = 8'h22;
  localparam logic [7:0] BACKSLASH = 8'h5C;
  localparam logic [7:0] LEAD_E0   = 8'hE0;
  localparam logic [7:0] LEAD_ED   = 8'hED;

  logic     clk = 1'b0;
  logic     rst;
  logic     item_valid;
  logic     item_ready;
  item_t    item;
  logic     verdict_valid;
  logic     verdict_ready;
  verdict_t verdict;

  int mismatches;
  int outstanding;

  // Bytes of the string that is sent next, and a flag that removes the
  // sender's idle gaps for the whole string.
  logic [7:0] text[$];
  bit         rush;
  int         items_sent = 0;

  always #(HALF_PERIOD_NS) clk = ~clk;

  json_utf8_string_validator u_dut (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .item          (item),
    .verdict_valid (verdict_valid),
    .verdict_ready (verdict_ready),
    .verdict       (verdict)
  );

  utf8_verdict_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .item          (item),
    .verdict_valid (verdict_valid),
    .verdict_ready (verdict_ready),
    .verdict       (verdict),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  // Offers one transaction on the byte channel. Every signal is driven with
  // a nonblocking assignment right at the rising edge, and item_ready is read
  // at the edge, before any register of the block has updated, so the check
  // for acceptance sees the value that the block used for this edge. When the
  // next transaction follows without a gap, item_valid simply stays high.
  task automatic push_item(input logic [7:0] b, input logic eos);
    int gap;
    gap = rush ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= '{data_byte: b, end_of_string: eos};
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    items_sent++;
  endtask

  // Sends the bytes held in text followed by the end-of-string transaction.
  // The byte field of the end transaction is random, since the block must
  // ignore it.
  task automatic send_text();
    foreach (text[i]) push_item(text[i], 1'b0);
    push_item(8'($urandom), 1'b1);
  endtask

  // Appends one well-formed unit: a safe printable character, a two-byte
  // sequence, or a three-byte sequence. The last kind picks the leads E0 and
  // ED on purpose, since those narrow the range of the first continuation.
  task automatic add_token();
    logic [7:0] lead;
    logic [7:0] c1;
    case ($urandom_range(0, 3))
      0: begin
        do lead = 8'($urandom_range(PRINT_LO, PRINT_HI));
        while (lead == QUOTE || lead == BACKSLASH);
        text.push_back(lead);
      end
      1: begin
        text.push_back(8'($urandom_range(8'hC2, 8'hDF)));
        text.push_back(8'($urandom_range(CONT_LO, CONT_HI)));
      end
      default: begin
        if ($urandom_range(0, 3) == 0) lead = $urandom_range(0, 1) ? LEAD_E0 : LEAD_ED;
        else lead = 8'($urandom_range(8'hE0, 8'hEF));
        if (lead == LEAD_E0) c1 = 8'($urandom_range(CONT_LO_E0, CONT_HI));
        else if (lead == LEAD_ED) c1 = 8'($urandom_range(CONT_LO, CONT_HI_ED));
        else c1 = 8'($urandom_range(CONT_LO, CONT_HI));
        text.push_back(lead);
        text.push_back(c1);
        text.push_back(8'($urandom_range(CONT_LO, CONT_HI)));
      end
    endcase
  endtask

  // Spoils a string in one of several ways: a stray byte slipped in, a cut
  // tail (often a truncated sequence), one byte overwritten, or plain noise.
  task automatic break_text();
    int at;
    case ($urandom_range(0, 3))
      0: begin
        at = $urandom_range(0, text.size());
        text.insert(at, 8'($urandom));
      end
      1: if (text.size() > 0) void'(text.pop_back());
      2: if (text.size() > 0) text[$urandom_range(0, text.size() - 1)] = 8'($urandom);
      default: begin
        text.delete();
        repeat ($urandom_range(1, 8)) text.push_back(8'($urandom));
      end
    endcase
  endtask

  // The result side takes a random pause after each verdict transaction and
  // then holds ready high until the next verdict arrives. Now and then it
  // switches into a stretch where it never pauses at all.
  initial begin
    int stall;
    bit drain_rush;
    drain_rush = 1'b0;
    forever begin
      if ($urandom_range(0, 7) == 0) drain_rush = !drain_rush;
      stall = drain_rush ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        verdict_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      verdict_ready <= 1'b1;
      @(posedge clk);
      while (!verdict_valid) @(posedge clk);
    end
  end

  // Stimulus and verdict.
  initial begin
    int random_start;
    rst        <= 1'b1;
    item_valid <= 1'b0;
    item       <= '0;
    rush        = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed strings. The empty string must pass with offset zero.
    text.delete();
    send_text();
    // Both ends of the printable range pass.
    text = '{8'h20, 8'h7E, 8'h41};
    send_text();
    // A zero data byte is a control character, not the end of the string.
    text = '{8'h41, 8'h00};
    send_text();
    // Double quote, backslash, the top control byte, DEL, an overlong lead,
    // a stray continuation and a lead of a four-byte sequence all fail at once.
    text = '{QUOTE};
    send_text();
    text = '{BACKSLASH};
    send_text();
    text = '{8'h1F};
    send_text();
    text = '{8'h7F};
    send_text();
    text = '{8'hC1, 8'h80};
    send_text();
    text = '{8'h80};
    send_text();
    text = '{8'hF0, 8'h90, 8'h80, 8'h80};
    send_text();
    text = '{8'hFF};
    send_text();
    // Boundaries of the two- and three-byte forms, including the narrowed
    // first continuation after E0 and ED.
    text = '{8'hC2, 8'h80, 8'hDF, 8'hBF};
    send_text();
    text = '{8'hE0, 8'hA0, 8'h80, 8'hED, 8'h9F, 8'hBF, 8'hEF, 8'hBF, 8'hBF};
    send_text();
    // A bad continuation is charged to its lead byte at offset 1.
    text = '{8'h41, 8'hE0, 8'h9F, 8'h80};
    send_text();
    // A surrogate, and a bad second continuation of a three-byte form.
    text = '{8'hED, 8'hA0, 8'h80};
    send_text();
    text = '{8'hE1, 8'h80, 8'hC0};
    send_text();
    // Truncated sequences at the end of the string.
    text = '{8'h41, 8'h42, 8'hE1, 8'h80};
    send_text();
    text = '{8'hC3};
    send_text();
    // Only the first error counts; the byte that broke a sequence is not
    // looked at again as a new lead.
    text = '{8'h41, 8'h01, 8'hC3};
    send_text();
    text = '{8'hC3, 8'h41, 8'h80};
    send_text();

    // Random strings: mostly well-formed with random content, about a third
    // of them spoiled on purpose.
    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      text.delete();
      repeat ($urandom_range(0, 8)) add_token();
      if ($urandom_range(0, 99) < 30) break_text();
      rush = ($urandom_range(0, 3) == 0);
      send_text();
    end
    item_valid <= 1'b0;

    // Let the checker see the last end transaction, wait for every verdict,
    // then wait out the tail period for anything the block should not send.
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[json_utf8_string_validator] OK");
    end else begin
      $display("[json_utf8_string_validator] ERROR");
    end
    $finish;
  end

  // Guard against a hang on either channel.
  initial begin
    #(TIMEOUT_NS);
    $display("[json_utf8_string_validator] ERROR");
    $finish;
  end

endmodule
